@@ rtl/rss_pkg.sv @@
// Shared types, constants and small lookup functions for the rotary scan sequencer.
// No dependencies; used by every rtl/rss_* module and the top level.
package rss_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_CW   = 2'd2,
    PH_BACK = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    MODE_TICK       = 2'd0,
    MODE_SAMPLE     = 2'd1,
    MODE_ACQ_BTN    = 2'd2,
    MODE_MOTOR_BTN  = 2'd3
  } mode_e;

  // Signed trig factor for one axis at a stop
  typedef enum logic [2:0] {
    FAC_ZERO     = 3'd0,
    FAC_POS_ONE  = 3'd1,
    FAC_POS_DIAG = 3'd2,
    FAC_NEG_DIAG = 3'd3,
    FAC_NEG_ONE  = 3'd4
  } fac_e;

  // Register indexes on the config port (byte address 4*index)
  typedef enum logic {
    REG_STEPS_PER_POS = 1'b0,
    REG_X_INCREMENT   = 1'b1
  } reg_e;

  localparam int unsigned SPP_W  = 12;
  localparam int unsigned XINC_W = 16;
  localparam int unsigned DIST_W = 16;
  localparam int unsigned POS_W  = 3;
  localparam int unsigned STEP_W = 15;
  localparam int unsigned X_W    = 24;
  localparam int unsigned Q8_W   = 25;
  localparam int unsigned ANG_W  = 9;

  localparam logic [SPP_W-1:0]  SPP_RESET  = 12'd256;
  localparam logic [XINC_W-1:0] XINC_RESET = 16'd100;
  localparam logic [POS_W-1:0]  LAST_POS   = 3'd7;
  localparam logic [X_W-1:0]    X_MAX      = 24'hFFFFFF;
  localparam logic [15:0]       DIAG_NUM   = 16'd46341;
  localparam logic [ANG_W-1:0]  ANGLE_STEP = 9'd45;

  typedef struct packed {
    logic [3:0]       coils;
    logic             point_valid;
    logic [POS_W-1:0] point_index;
    logic [X_W-1:0]   x_mm;
    logic             acquiring;
    logic             motor_on;
    logic             scanning;
  } status_t;

  function automatic logic [3:0] cw_coils(input logic [1:0] ph);
    logic [3:0] c;
    unique case (ph)
      2'd0:    c = 4'b0011;
      2'd1:    c = 4'b0110;
      2'd2:    c = 4'b1100;
      default: c = 4'b1001;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] ccw_coils(input logic [1:0] ph);
    logic [3:0] c;
    unique case (ph)
      2'd0:    c = 4'b1001;
      2'd1:    c = 4'b1100;
      2'd2:    c = 4'b0110;
      default: c = 4'b0011;
    endcase
    return c;
  endfunction

  function automatic fac_e cos_fac(input logic [POS_W-1:0] idx);
    fac_e f;
    unique case (idx)
      3'd0:    f = FAC_POS_ONE;
      3'd1:    f = FAC_POS_DIAG;
      3'd2:    f = FAC_ZERO;
      3'd3:    f = FAC_NEG_DIAG;
      3'd4:    f = FAC_NEG_ONE;
      3'd5:    f = FAC_NEG_DIAG;
      3'd6:    f = FAC_ZERO;
      default: f = FAC_POS_DIAG;
    endcase
    return f;
  endfunction

  function automatic fac_e sin_fac(input logic [POS_W-1:0] idx);
    fac_e f;
    unique case (idx)
      3'd0:    f = FAC_ZERO;
      3'd1:    f = FAC_POS_DIAG;
      3'd2:    f = FAC_POS_ONE;
      3'd3:    f = FAC_POS_DIAG;
      3'd4:    f = FAC_ZERO;
      3'd5:    f = FAC_NEG_DIAG;
      3'd6:    f = FAC_NEG_ONE;
      default: f = FAC_NEG_DIAG;
    endcase
    return f;
  endfunction

endpackage

@@ rtl/rss_cfg_regs.sv @@
// APB-style config registers: steps per position and x increment.
// Depends on rss_pkg.
module rss_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [rss_pkg::SPP_W-1:0]    spp_o,
  output logic [rss_pkg::XINC_W-1:0]   xinc_o
);

  logic [rss_pkg::SPP_W-1:0]  spp_q;
  logic [rss_pkg::XINC_W-1:0] xinc_q;
  logic                       wr_en;
  rss_pkg::reg_e              sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign sel    = rss_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spp_q  <= rss_pkg::SPP_RESET;
      xinc_q <= rss_pkg::XINC_RESET;
    end else if (wr_en) begin
      unique case (sel)
        rss_pkg::REG_STEPS_PER_POS: spp_q  <= pwdata[rss_pkg::SPP_W-1:0];
        rss_pkg::REG_X_INCREMENT:   xinc_q <= pwdata[rss_pkg::XINC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      rss_pkg::REG_STEPS_PER_POS: prdata = {20'd0, spp_q};
      rss_pkg::REG_X_INCREMENT:   prdata = {16'd0, xinc_q};
      default:                    prdata = 32'd0;
    endcase
  end

  assign spp_o  = spp_q;
  assign xinc_o = xinc_q;

endmodule

@@ rtl/rss_point.sv @@
// Point geometry: y = d*cos, z = d*sin in 1/256 mm, one shared 16x16 multiplier.
// Depends on rss_pkg.
module rss_point (
  input  logic [rss_pkg::DIST_W-1:0]     dist_i,
  input  logic [rss_pkg::POS_W-1:0]      idx_i,
  output logic signed [rss_pkg::Q8_W-1:0] y_q8_o,
  output logic signed [rss_pkg::Q8_W-1:0] z_q8_o
);

  logic [31:0] prod;
  logic [32:0] prod_rnd;
  logic [23:0] diag_mag;
  logic [23:0] axis_mag;

  // d*46341/256, rounded half up (magnitude is never negative here)
  assign prod     = dist_i * rss_pkg::DIAG_NUM;
  assign prod_rnd = {1'b0, prod} + 33'd128;
  assign diag_mag = prod_rnd[31:8];
  assign axis_mag = {dist_i, 8'd0};

  function automatic logic signed [rss_pkg::Q8_W-1:0] apply_fac(
    input rss_pkg::fac_e f, input logic [23:0] axis, input logic [23:0] diag);
    logic signed [rss_pkg::Q8_W-1:0] v;
    unique case (f)
      rss_pkg::FAC_ZERO:     v = '0;
      rss_pkg::FAC_POS_ONE:  v = $signed({1'b0, axis});
      rss_pkg::FAC_POS_DIAG: v = $signed({1'b0, diag});
      rss_pkg::FAC_NEG_DIAG: v = -$signed({1'b0, diag});
      rss_pkg::FAC_NEG_ONE:  v = -$signed({1'b0, axis});
      default:               v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    y_q8_o = apply_fac(rss_pkg::cos_fac(idx_i), axis_mag, diag_mag);
    z_q8_o = apply_fac(rss_pkg::sin_fac(idx_i), axis_mag, diag_mag);
  end

endmodule

@@ rtl/rss_ctrl.sv @@
// Scan sequencer state: phase, stop, step count, coil drive, x offset, flags.
// Depends on rss_pkg.
module rss_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  rss_pkg::mode_e              mode_i,
  input  logic [rss_pkg::SPP_W-1:0]   spp_i,
  input  logic [rss_pkg::XINC_W-1:0]  xinc_i,
  output rss_pkg::status_t            status_o
);

  rss_pkg::phase_e             phase_q, phase_d;
  logic [rss_pkg::POS_W-1:0]   position_q, position_d;
  logic [rss_pkg::STEP_W-1:0]  step_q, step_d;
  logic [1:0]                  coil_ph_q, coil_ph_d;
  logic [3:0]                  coil_q, coil_d;
  logic [rss_pkg::X_W-1:0]     x_q, x_d;
  logic                        acq_q, acq_d;
  logic                        motor_q, motor_d;
  logic                        pt_valid;

  always_comb begin
    logic [rss_pkg::STEP_W-1:0] step_inc;
    logic [rss_pkg::STEP_W-1:0] back_target;
    logic [rss_pkg::X_W:0]      x_sum;
    logic                       done;
    phase_d    = phase_q;
    position_d = position_q;
    step_d     = step_q;
    coil_ph_d  = coil_ph_q;
    coil_d     = coil_q;
    x_d        = x_q;
    acq_d      = acq_q;
    motor_d    = motor_q;
    pt_valid   = 1'b0;
    step_inc    = step_q + 15'd1;
    back_target = {spp_i, 3'b000};
    x_sum       = {1'b0, x_q} + 25'(xinc_i);
    done        = 1'b1;
    if (fire_i) begin
      unique case (mode_i)
        rss_pkg::MODE_ACQ_BTN: acq_d = ~acq_q;
        rss_pkg::MODE_MOTOR_BTN: begin
          acq_d   = 1'b1;
          motor_d = ~motor_q;
        end
        rss_pkg::MODE_SAMPLE: begin
          if (phase_q == rss_pkg::PH_WAIT) begin
            pt_valid = 1'b1;
            phase_d  = rss_pkg::PH_CW;
            step_d   = '0;
          end
        end
        default: begin
          unique case (phase_q)
            rss_pkg::PH_IDLE: begin
              // scan start does not step the motor
              if (acq_q && motor_q) begin
                x_d        = '0;
                position_d = '0;
                step_d     = '0;
                phase_d    = rss_pkg::PH_WAIT;
              end
            end
            rss_pkg::PH_CW: begin
              if (motor_q) begin
                coil_d    = rss_pkg::cw_coils(coil_ph_q);
                coil_ph_d = coil_ph_q + 2'd1;
                step_d    = step_inc;
                done      = step_inc >= 15'(spp_i);
              end
              if (done) begin
                step_d = '0;
                if (position_q == rss_pkg::LAST_POS) begin
                  phase_d = rss_pkg::PH_BACK;
                end else begin
                  position_d = position_q + 3'd1;
                  phase_d    = acq_q ? rss_pkg::PH_WAIT : rss_pkg::PH_CW;
                end
              end
            end
            rss_pkg::PH_BACK: begin
              if (motor_q) begin
                coil_d    = rss_pkg::ccw_coils(coil_ph_q);
                coil_ph_d = coil_ph_q + 2'd1;
                step_d    = step_inc;
                done      = step_inc >= back_target;
              end
              if (done) begin
                x_d    = x_sum[rss_pkg::X_W] ? rss_pkg::X_MAX : x_sum[rss_pkg::X_W-1:0];
                step_d = '0;
                if (motor_q) begin
                  position_d = '0;
                  phase_d    = acq_q ? rss_pkg::PH_WAIT : rss_pkg::PH_CW;
                end else begin
                  phase_d = rss_pkg::PH_IDLE;
                end
              end
            end
            default: ;  // waiting for a sample: ticks do nothing
          endcase
        end
      endcase
    end
  end

  // Result status reflects state after this word, point fields before it
  always_comb begin
    status_o.coils       = coil_d;
    status_o.point_valid = pt_valid;
    status_o.point_index = position_q;
    status_o.x_mm        = x_q;
    status_o.acquiring   = acq_d;
    status_o.motor_on    = motor_d;
    status_o.scanning    = (phase_d != rss_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rss_pkg::PH_IDLE;
      position_q <= '0;
      step_q     <= '0;
      coil_ph_q  <= '0;
      coil_q     <= '0;
      x_q        <= '0;
      acq_q      <= 1'b0;
      motor_q    <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      position_q <= position_d;
      step_q     <= step_d;
      coil_ph_q  <= coil_ph_d;
      coil_q     <= coil_d;
      x_q        <= x_d;
      acq_q      <= acq_d;
      motor_q    <= motor_d;
    end
  end

`ifndef SYNTHESIS
  a_idle_no_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rss_pkg::PH_IDLE) |-> (step_q == '0))
    else $error("step count not cleared in idle");

  a_coils_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(coil_q))
    else $error("coil drive changed without a word");

  a_coils_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(coil_q) == 0) || ($countones(coil_q) == 2))
    else $error("coil drive is not a full-step pattern");
`endif

endmodule

@@ rtl/rotary_scan_sequencer_top.sv @@
// Top level of the rotary scan sequencer: input register, control and point
// logic, output register. Depends on rss_pkg, rss_cfg_regs, rss_ctrl, rss_point.
//
//  channel   | dir | handshake                  | payload
//  s_axis    | in  | s_axis_tvalid/tready       | tdata: distance_mm; tuser: mode
//  m_axis    | out | m_axis_tvalid/tready       | tdata: point/status; tuser: point_valid
//  apb       | in  | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One word per cycle sustained while m_axis_tready stays high; input register, then result register.
// The single 16x16 multiply in the point logic sets the path between the registers.
// Reset (rst_ni, async low) empties both registers and clears the scan state.
// s_axis_tready stays high while the result register can drain or is empty;
// a stalled result holds the next input word in the input register.
module rotary_scan_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] distance_mm
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] coils, [6:4] point_index, [15:7] angle, [39:16] x_mm,
  // [64:40] y_q8, [89:65] z_q8, [90] acquiring, [91] motor_on, [92] scanning
  output logic [95:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] point_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                          in_valid_q;
  rss_pkg::mode_e                in_mode_q;
  logic [rss_pkg::DIST_W-1:0]    in_dist_q;
  logic                          out_valid_q;
  logic [95:0]                   out_data_q, out_data_d;
  logic                          out_user_q;
  logic                          adv;
  logic                          fire;
  logic [rss_pkg::SPP_W-1:0]     spp;
  logic [rss_pkg::XINC_W-1:0]    xinc;
  rss_pkg::status_t              status;
  logic signed [rss_pkg::Q8_W-1:0] y_q8, z_q8;

  assign adv           = ~out_valid_q | m_axis_tready;
  assign fire          = in_valid_q & adv;
  assign s_axis_tready = ~in_valid_q | adv;

  rss_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .spp_o   (spp),
    .xinc_o  (xinc)
  );

  rss_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .mode_i   (in_mode_q),
    .spp_i    (spp),
    .xinc_i   (xinc),
    .status_o (status)
  );

  rss_point u_point (
    .dist_i (in_dist_q),
    .idx_i  (status.point_index),
    .y_q8_o (y_q8),
    .z_q8_o (z_q8)
  );

  // Point fields read as zero when the word carries no point
  always_comb begin
    logic [rss_pkg::POS_W-1:0] idx;
    logic [rss_pkg::ANG_W-1:0] ang;
    logic [rss_pkg::X_W-1:0]   x;
    logic [rss_pkg::Q8_W-1:0]  y;
    logic [rss_pkg::Q8_W-1:0]  z;
    idx = status.point_valid ? status.point_index : '0;
    ang = 9'(idx) * rss_pkg::ANGLE_STEP;
    x   = status.point_valid ? status.x_mm : '0;
    y   = status.point_valid ? y_q8 : '0;
    z   = status.point_valid ? z_q8 : '0;
    out_data_d = {3'b000, status.scanning, status.motor_on, status.acquiring,
                  z, y, x, ang, idx, status.coils};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q <= rss_pkg::mode_e'(s_axis_tuser);
      in_dist_q <= s_axis_tdata;
    end
    if (fire) begin
      out_data_q <= out_data_d;
      out_user_q <= status.point_valid;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

@@ tb/rotary_scan_sequencer_top_tb.sv @@
// Self-checking testbench for rotary_scan_sequencer_top: streams mode/distance words,
// predicts each status word in its own scan model and checks the output stream.
// Depends on rss_pkg and the rotary_scan_sequencer_top RTL.
`timescale 1ns / 100ps

module rotary_scan_sequencer_top_tb;
  import rss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_AT     = 150;   // status count that starts the long stall
  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned CALM_LO     = 400;   // words in this window see no idling
  localparam int unsigned CALM_HI     = 650;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned MAX_REPORTS = 100;

  localparam logic [3:0] CW_COILS [4] = '{4'b0011, 4'b0110, 4'b1100, 4'b1001};

  typedef struct packed {
    logic [3:0]  coils;
    logic        point_valid;
    logic [2:0]  point_index;
    logic [8:0]  angle;
    logic [23:0] x_mm;
    logic [24:0] y_q8;
    logic [24:0] z_q8;
    logic        acquiring;
    logic        motor_on;
    logic        scanning;
  } scan_point_t;

  typedef struct packed {
    mode_e       md;
    logic [15:0] range_mm;
    scan_point_t want;
  } scan_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rotary_scan_sequencer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  // Scan model state and register copies
  logic [11:0] steps_per_stop = SPP_RESET;
  logic [15:0] x_step = XINC_RESET;
  phase_e      scan_ph = PH_IDLE;
  logic [2:0]  stop_idx = '0;
  logic [14:0] step_cnt = '0;
  logic [1:0]  coil_idx = '0;
  logic [3:0]  coil_out = '0;
  logic [23:0] x_base = '0;
  logic        acq_flag = 1'b0;
  logic        motor_flag = 1'b0;

  scan_word_t  word_feed[$];
  scan_point_t status_due[$];
  scan_word_t  word_on_bus;
  scan_point_t seen;
  scan_point_t due;
  int unsigned words_sent = 0;
  int unsigned status_seen = 0;
  int unsigned hold_left = 0;
  bit          held = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int          errs;

  function automatic fac_e cos_factor(logic [2:0] idx);
    fac_e f;
    case (idx)
      3'd0:       f = FAC_POS_ONE;
      3'd1, 3'd7: f = FAC_POS_DIAG;
      3'd2, 3'd6: f = FAC_ZERO;
      3'd3, 3'd5: f = FAC_NEG_DIAG;
      default:    f = FAC_NEG_ONE;
    endcase
    return f;
  endfunction

  // d * factor in 1/256 mm; diagonal magnitude rounds half up before the sign
  function automatic logic [24:0] scale_q8(logic [15:0] d, fac_e f);
    logic [32:0] mag;
    case (f)
      FAC_POS_ONE, FAC_NEG_ONE:   mag = {9'd0, d, 8'd0};
      FAC_POS_DIAG, FAC_NEG_DIAG: mag = (33'(d) * 33'(DIAG_NUM) + 33'd128) >> 8;
      default:                    mag = '0;
    endcase
    if (f == FAC_NEG_ONE || f == FAC_NEG_DIAG) begin
      mag = -mag;
    end
    return mag[24:0];
  endfunction

  function automatic void open_stop();
    step_cnt = '0;
    if (acq_flag) begin
      scan_ph = PH_WAIT;
    end else begin
      scan_ph = PH_CW;
    end
  endfunction

  function automatic scan_point_t advance_scan(mode_e md, logic [15:0] rng);
    scan_point_t p;
    logic        done;
    logic [24:0] nx;
    p = '0;
    done = 1'b1;
    case (md)
      MODE_ACQ_BTN: acq_flag = ~acq_flag;
      MODE_MOTOR_BTN: begin
        acq_flag = 1'b1;
        motor_flag = ~motor_flag;
      end
      MODE_SAMPLE: begin
        if (scan_ph == PH_WAIT) begin
          p.point_valid = 1'b1;
          p.point_index = stop_idx;
          p.angle = 9'(stop_idx) * ANGLE_STEP;
          p.x_mm = x_base;
          p.y_q8 = scale_q8(rng, cos_factor(stop_idx));
          // sine at this stop is the cosine two stops back
          p.z_q8 = scale_q8(rng, cos_factor(stop_idx + 3'd6));
          scan_ph = PH_CW;
          step_cnt = '0;
        end
      end
      default: begin
        case (scan_ph)
          PH_IDLE: begin
            if (acq_flag && motor_flag) begin
              x_base = '0;
              stop_idx = '0;
              open_stop();
            end
          end
          PH_CW: begin
            if (motor_flag) begin
              coil_out = CW_COILS[coil_idx];
              coil_idx++;
              step_cnt++;
              done = step_cnt >= 15'(steps_per_stop);
            end
            if (done) begin
              if (stop_idx == LAST_POS) begin
                scan_ph = PH_BACK;
                step_cnt = '0;
              end else begin
                stop_idx++;
                open_stop();
              end
            end
          end
          PH_BACK: begin
            if (motor_flag) begin
              coil_out = CW_COILS[~coil_idx];
              coil_idx++;
              step_cnt++;
              done = step_cnt >= {steps_per_stop, 3'b000};  // eight stops' worth
            end
            if (done) begin
              nx = {1'b0, x_base} + 25'(x_step);
              x_base = nx[24] ? X_MAX : nx[23:0];
              if (motor_flag) begin
                stop_idx = '0;
                open_stop();
              end else begin
                scan_ph = PH_IDLE;
                step_cnt = '0;
              end
            end
          end
          default: ;
        endcase
      end
    endcase
    p.coils = coil_out;
    p.acquiring = acq_flag;
    p.motor_on = motor_flag;
    p.scanning = scan_ph != PH_IDLE;
    return p;
  endfunction

  task automatic add_word(mode_e md, logic [15:0] rng);
    scan_word_t w;
    w.md = md;
    w.range_mm = rng;
    w.want = advance_scan(md, rng);
    word_feed.push_back(w);
  endtask

  // Mode choice follows the model's phase so most words move the scan forward
  task automatic queue_random(int unsigned n);
    int unsigned r;
    int unsigned k;
    mode_e       md;
    logic [15:0] d;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (scan_ph == PH_IDLE && !(acq_flag && motor_flag)) begin
        md = r < 45 ? MODE_MOTOR_BTN : r < 70 ? MODE_ACQ_BTN : r < 85 ? MODE_TICK : MODE_SAMPLE;
      end else if (scan_ph == PH_IDLE) begin
        md = r < 80 ? MODE_TICK : r < 90 ? MODE_SAMPLE : r < 95 ? MODE_ACQ_BTN : MODE_MOTOR_BTN;
      end else if (scan_ph == PH_WAIT) begin
        md = r < 70 ? MODE_SAMPLE : r < 92 ? MODE_TICK : r < 97 ? MODE_ACQ_BTN : MODE_MOTOR_BTN;
      end else begin
        md = r < 82 ? MODE_TICK : r < 94 ? MODE_SAMPLE : r < 98 ? MODE_ACQ_BTN : MODE_MOTOR_BTN;
      end
      k = $urandom_range(15);
      d = k == 0 ? 16'h0000 : k == 1 ? 16'hFFFF : 16'($urandom);
      add_word(md, d);
    end
  endtask

  task automatic cfg_write(reg_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_STEPS_PER_POS) begin
      steps_per_stop = value[11:0];
    end else begin
      x_step = value[15:0];
    end
  endtask

  // Sender holds off until every word is in and every status word is out
  task automatic settle();
    do @(negedge clk_i);
    while (word_feed.size() != 0 || s_axis_tvalid || status_due.size() != 0);
  endtask

  function automatic int diff_field(string name, logic [31:0] want, logic [31:0] got);
    if (want === got) begin
      return 0;
    end
    if (mismatches < MAX_REPORTS) begin
      $display("%0t: status %0d %s expected %0h actual %0h", $time, status_seen, name, want,
               got);
    end
    return 1;
  endfunction

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        status_due.push_back(word_on_bus.want);
        words_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (word_feed.size() != 0 && ((words_sent >= CALM_LO && words_sent < CALM_HI)
                                      || $urandom_range(99) >= 31)) begin
          word_on_bus = word_feed.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= word_on_bus.range_mm;
          s_axis_tuser <= word_on_bus.md;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.coils = m_axis_tdata[3:0];
        seen.point_valid = m_axis_tuser;
        seen.point_index = m_axis_tdata[6:4];
        seen.angle = m_axis_tdata[15:7];
        seen.x_mm = m_axis_tdata[39:16];
        seen.y_q8 = m_axis_tdata[64:40];
        seen.z_q8 = m_axis_tdata[89:65];
        seen.acquiring = m_axis_tdata[90];
        seen.motor_on = m_axis_tdata[91];
        seen.scanning = m_axis_tdata[92];
        if (status_due.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("%0t: unexpected status word, expected none actual %0h", $time,
                     m_axis_tdata);
          end
          mismatches++;
        end else begin
          due = status_due.pop_front();
          errs = diff_field("coils", due.coils, seen.coils)
               + diff_field("point_valid", due.point_valid, seen.point_valid)
               + diff_field("point_index", due.point_index, seen.point_index)
               + diff_field("angle", due.angle, seen.angle)
               + diff_field("x_mm", due.x_mm, seen.x_mm)
               + diff_field("y_q8", due.y_q8, seen.y_q8)
               + diff_field("z_q8", due.z_q8, seen.z_q8)
               + diff_field("acquiring", due.acquiring, seen.acquiring)
               + diff_field("motor_on", due.motor_on, seen.motor_on)
               + diff_field("scanning", due.scanning, seen.scanning)
               + diff_field("pad", '0, m_axis_tdata[95:93]);
          mismatches += errs;
        end
        status_seen++;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (status_seen == HOLD_AT && !held) begin
        // long stall: input side keeps offering until the block backs up
        held = 1'b1;
        hold_left = HOLD_LEN;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (status_seen >= CALM_LO && status_seen < CALM_HI)
                         || $urandom_range(99) >= 31;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("rotary_scan_sequencer_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned guard;
    mode_e       md;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening, registers at reset values
    add_word(MODE_SAMPLE, 16'h1234);     // sample while idle gives no point
    add_word(MODE_TICK, 16'h0000);       // tick idle with neither flag
    add_word(MODE_ACQ_BTN, 16'h0000);
    add_word(MODE_TICK, 16'hFFFF);       // tick idle with acquire only
    add_word(MODE_ACQ_BTN, 16'h0000);
    add_word(MODE_MOTOR_BTN, 16'h0000);  // motor button also sets acquire
    add_word(MODE_TICK, 16'h0000);       // scan start, stop 0 waits
    add_word(MODE_TICK, 16'h0000);       // tick while waiting
    add_word(MODE_ACQ_BTN, 16'h0000);    // acquire off while waiting
    add_word(MODE_SAMPLE, 16'hFFFF);
    add_word(MODE_TICK, 16'h0000);
    add_word(MODE_TICK, 16'h0000);
    add_word(MODE_MOTOR_BTN, 16'h0000);
    add_word(MODE_TICK, 16'h0000);       // tick with motor off moves to the next stop unstepped
    add_word(MODE_SAMPLE, 16'h0000);
    add_word(MODE_MOTOR_BTN, 16'h0000);
    add_word(MODE_TICK, 16'h5555);
    add_word(MODE_SAMPLE, 16'hAAAA);

    settle();
    cfg_write(REG_STEPS_PER_POS, 32'd1);
    cfg_write(REG_X_INCREMENT, 32'hFFFF);
    @(negedge clk_i);
    // Short full rotations with acquire off and the largest x increment
    guard = 0;
    while (guard < 100) begin
      if (scan_ph == PH_WAIT) begin
        md = MODE_SAMPLE;
      end else if (scan_ph != PH_IDLE && acq_flag) begin
        md = MODE_ACQ_BTN;
      end else if (scan_ph == PH_IDLE && !motor_flag) begin
        md = MODE_MOTOR_BTN;
      end else if (scan_ph == PH_IDLE && !acq_flag) begin
        md = MODE_ACQ_BTN;
      end else begin
        md = MODE_TICK;
      end
      add_word(md, 16'($urandom));
      guard++;
    end
    queue_random(150);

    settle();
    cfg_write(REG_STEPS_PER_POS, 32'd2);
    cfg_write(REG_X_INCREMENT, 32'd0);
    @(negedge clk_i);
    queue_random(250);

    settle();
    cfg_write(REG_STEPS_PER_POS, 32'($urandom_range(3, 6)));
    cfg_write(REG_X_INCREMENT, 32'($urandom_range(16'hFFFF)));
    @(negedge clk_i);
    queue_random(250);

    settle();
    cfg_write(REG_STEPS_PER_POS, 32'd4095);
    cfg_write(REG_X_INCREMENT, 32'd1);
    @(negedge clk_i);
    queue_random(150);

    settle();
    cfg_write(REG_STEPS_PER_POS, 32'd1);
    cfg_write(REG_X_INCREMENT, 32'd100);
    @(negedge clk_i);
    queue_random(100);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("rotary_scan_sequencer_top_tb OK");
    end else begin
      $display("rotary_scan_sequencer_top_tb NOT OK");
    end
    $finish;
  end

endmodule
